/* rtl/core/atsc_pkg.sv */
package atsc_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [CFG_W-1:0]     cfg_val_t;
  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [PHASE_W-1:0]   phase_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam phase_t PH_GREEN_A  = 3'd0;
  localparam phase_t PH_YELLOW_A = 3'd1;
  localparam phase_t PH_GREEN_B  = 3'd2;
  localparam phase_t PH_YELLOW_B = 3'd3;
  localparam phase_t PH_WALK     = 3'd4;

  localparam cmd_t CMD_NONE     = 3'd0;
  localparam cmd_t CMD_DETECT_A = 3'd1;
  localparam cmd_t CMD_DETECT_B = 3'd2;
  localparam cmd_t CMD_PED      = 3'd3;
  localparam cmd_t CMD_RESTART  = 3'd4;

  localparam cfg_idx_t REG_GAP_TIME    = 3'd0;
  localparam cfg_idx_t REG_MIN_GREEN   = 3'd1;
  localparam cfg_idx_t REG_YELLOW_TIME = 3'd2;
  localparam cfg_idx_t REG_MAX_GREEN   = 3'd3;
  localparam cfg_idx_t REG_WALK_TIME   = 3'd4;

  localparam cfg_val_t RST_GAP_TIME    = 16'd5000;
  localparam cfg_val_t RST_MIN_GREEN   = 16'd5000;
  localparam cfg_val_t RST_YELLOW_TIME = 16'd2000;
  localparam cfg_val_t RST_MAX_GREEN   = 16'd15000;
  localparam cfg_val_t RST_WALK_TIME   = 16'd5000;

endpackage

/* rtl/core/atsc_in_if.sv */
interface atsc_in_if;
  logic                 valid;
  logic                 ready;
  atsc_pkg::cmd_t       command;
  logic                 ped_button;

  modport source (output valid, output command, output ped_button, input ready);
  modport sink   (input valid, input command, input ped_button, output ready);
endinterface

/* rtl/core/atsc_out_if.sv */
interface atsc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 a_green;
  logic                 a_yellow;
  logic                 a_red;
  logic                 b_green;
  logic                 b_yellow;
  logic                 b_red;
  logic                 walk_on;
  logic                 dont_walk_on;
  atsc_pkg::phase_t     phase_code;

  modport source (
    output valid, output a_green, output a_yellow, output a_red,
    output b_green, output b_yellow, output b_red, output walk_on,
    output dont_walk_on, output phase_code, input ready
  );
  modport sink (
    input valid, input a_green, input a_yellow, input a_red,
    input b_green, input b_yellow, input b_red, input walk_on,
    input dont_walk_on, input phase_code, output ready
  );
endinterface

/* rtl/core/atsc_cfg_if.sv */
interface atsc_cfg_if;
  logic                 valid;
  logic                 ready;
  atsc_pkg::cfg_idx_t   index;
  atsc_pkg::cfg_val_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/actuated_two_way_signal_controller_top.sv */
// Two-approach actuated signal controller, one item per millisecond tick.
// in_ch  : command (none, detect A, detect B, pedestrian request, restart)
//          and the pedestrian button state for the tick.
// out_ch : lamp states and phase code after the tick, one result per item.
// cfg_ch : register writes (0 gap_time, 1 min_green, 2 yellow_time,
//          3 max_green, 4 walk_time); always ready, unknown indexes ignored.
//          Write only while no item is in flight.
// The result appears in the output register in the cycle after the item is
// accepted. Throughput: one item per cycle while the output is taken, set by
// the single registered update of the phase state and its timers.
// Stall: in_ch.ready stays high while the output register is empty or being
// taken in the same cycle, so a held result blocks only further items.
// Reset (rst_n low, synchronous): green A with B next, timers zero, no
// pedestrian request, registers at their defaults, output register empty.
module actuated_two_way_signal_controller_top #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  atsc_in_if.sink           in_ch,
  atsc_out_if.source        out_ch,
  atsc_cfg_if.sink          cfg_ch
);

  localparam int unsigned CMP_W = (TIMER_BITS > atsc_pkg::CFG_W) ? TIMER_BITS
                                                                 : atsc_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  atsc_pkg::cfg_val_t gap_time_r, min_green_r, yellow_time_r, max_green_r, walk_time_r;

  atsc_pkg::phase_t        phase_r, phase_nxt;
  logic                    next_b_r, next_b_nxt;
  logic [TIMER_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0]   since_a_r, since_a_nxt;
  logic [TIMER_BITS-1:0]   since_b_r, since_b_nxt;
  logic                    ped_r, ped_nxt;

  logic                    out_valid_r;
  atsc_pkg::phase_t        out_phase_r;

  logic                    in_acc;
  logic                    green;
  logic [CMP_W-1:0]        el_x, since_x;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    sat_inc = (v == TIMER_MAX) ? v : v + 1'b1;
  endfunction

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_time_r    <= atsc_pkg::RST_GAP_TIME;
      min_green_r   <= atsc_pkg::RST_MIN_GREEN;
      yellow_time_r <= atsc_pkg::RST_YELLOW_TIME;
      max_green_r   <= atsc_pkg::RST_MAX_GREEN;
      walk_time_r   <= atsc_pkg::RST_WALK_TIME;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        atsc_pkg::REG_GAP_TIME:    gap_time_r    <= cfg_ch.data;
        atsc_pkg::REG_MIN_GREEN:   min_green_r   <= cfg_ch.data;
        atsc_pkg::REG_YELLOW_TIME: yellow_time_r <= cfg_ch.data;
        atsc_pkg::REG_MAX_GREEN:   max_green_r   <= cfg_ch.data;
        atsc_pkg::REG_WALK_TIME:   walk_time_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    green       = (phase_r == atsc_pkg::PH_GREEN_A) || (phase_r == atsc_pkg::PH_GREEN_B);
    phase_nxt   = phase_r;
    next_b_nxt  = next_b_r;
    elapsed_nxt = sat_inc(elapsed_r);
    since_a_nxt = sat_inc(since_a_r);
    since_b_nxt = sat_inc(since_b_r);
    ped_nxt     = ped_r;

    if (green) begin
      case (in_ch.command)
        atsc_pkg::CMD_DETECT_A: since_a_nxt = '0;
        atsc_pkg::CMD_DETECT_B: since_b_nxt = '0;
        atsc_pkg::CMD_PED:      ped_nxt = 1'b1;
        atsc_pkg::CMD_RESTART: begin
          ped_nxt     = 1'b0;
          since_a_nxt = '0;
          since_b_nxt = '0;
          phase_nxt   = atsc_pkg::PH_GREEN_A;
          next_b_nxt  = 1'b1;
          elapsed_nxt = '0;
        end
        default: ;
      endcase
    end
    if (in_ch.ped_button) begin
      ped_nxt = 1'b1;
    end

    el_x    = CMP_W'(elapsed_nxt);
    since_x = (phase_nxt == atsc_pkg::PH_GREEN_A) ? CMP_W'(since_a_nxt)
                                                  : CMP_W'(since_b_nxt);

    case (phase_nxt)
      atsc_pkg::PH_GREEN_A, atsc_pkg::PH_GREEN_B: begin
        if (el_x >= CMP_W'(min_green_r) &&
            (since_x > CMP_W'(gap_time_r) || el_x > CMP_W'(max_green_r))) begin
          phase_nxt   = (phase_nxt == atsc_pkg::PH_GREEN_A) ? atsc_pkg::PH_YELLOW_A
                                                            : atsc_pkg::PH_YELLOW_B;
          elapsed_nxt = '0;
        end
      end
      atsc_pkg::PH_YELLOW_A, atsc_pkg::PH_YELLOW_B: begin
        if (el_x >= CMP_W'(yellow_time_r)) begin
          elapsed_nxt = '0;
          if (ped_nxt) begin
            phase_nxt = atsc_pkg::PH_WALK;
          end else begin
            phase_nxt  = next_b_r ? atsc_pkg::PH_GREEN_B : atsc_pkg::PH_GREEN_A;
            next_b_nxt = !next_b_r;
          end
        end
      end
      default: begin
        if (el_x >= CMP_W'(walk_time_r)) begin
          ped_nxt     = 1'b0;
          elapsed_nxt = '0;
          phase_nxt   = next_b_r ? atsc_pkg::PH_GREEN_B : atsc_pkg::PH_GREEN_A;
          next_b_nxt  = !next_b_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= atsc_pkg::PH_GREEN_A;
      next_b_r    <= 1'b1;
      elapsed_r   <= '0;
      since_a_r   <= '0;
      since_b_r   <= '0;
      ped_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        next_b_r    <= next_b_nxt;
        elapsed_r   <= elapsed_nxt;
        since_a_r   <= since_a_nxt;
        since_b_r   <= since_b_nxt;
        ped_r       <= ped_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_phase_r <= phase_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.phase_code   = out_phase_r;
  assign out_ch.a_green      = (out_phase_r == atsc_pkg::PH_GREEN_A);
  assign out_ch.a_yellow     = (out_phase_r == atsc_pkg::PH_YELLOW_A);
  assign out_ch.a_red        = !out_ch.a_green && !out_ch.a_yellow;
  assign out_ch.b_green      = (out_phase_r == atsc_pkg::PH_GREEN_B);
  assign out_ch.b_yellow     = (out_phase_r == atsc_pkg::PH_YELLOW_B);
  assign out_ch.b_red        = !out_ch.b_green && !out_ch.b_yellow;
  assign out_ch.walk_on      = (out_phase_r == atsc_pkg::PH_WALK);
  assign out_ch.dont_walk_on = !out_ch.walk_on;

`ifndef ASSERT_OFF
  a_walk_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == atsc_pkg::PH_WALK |-> ped_r)
    else $error("walk phase without a latched pedestrian request");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r && out_phase_r == phase_r)
    else $error("result register does not match updated phase");

  a_no_double_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ch.a_green && out_ch.b_green) &&
                    !(out_ch.walk_on && (out_ch.a_green || out_ch.b_green)))
    else $error("conflicting green lamps");

  a_elapsed_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_nxt == phase_r && !(green && in_ch.command == atsc_pkg::CMD_RESTART)
      |=> elapsed_r == sat_inc($past(elapsed_r)))
    else $error("phase timer did not advance within a phase");
`endif

endmodule
